// ===== sv/two_list_sorted_merge_core_defines.svh =====
// Assertion macros shared by the merge core RTL.
`ifndef TWO_LIST_SORTED_MERGE_CORE_DEFINES_SVH
`define TWO_LIST_SORTED_MERGE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TLSM_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define TLSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TLSM_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TLSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/tlsm_pkg.sv =====
// Shared constants and types of the two-list merge core.
package tlsm_pkg;

  localparam int LIST_DEPTH_DEF = 32;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_MERGE
  } state_t;

endpackage

// ===== sv/two_list_sorted_merge_core.sv =====
// Top level of the two-list sorted merge core.
//
//  Port group   Way   Handshake            Carries
//  in_*         in    in_valid/in_ready    in_mode, in_elem_value, in_load_done
//  out_*        out   out_valid/out_ready  out_merged_value, out_from_second,
//                                          out_final_out, out_overflowed
//
// A load request produces no result.
// A request with in_load_done set is stored, then the ST_PREP setup state primes the
// registered list reads, and the merge loads one result per cycle while out_ready is high.
// in_ready stays low from the final load request until the last result is
// registered; out_ready low holds the merge in place.
// Reset is synchronous and clears the list counts and the drop flag.
module two_list_sorted_merge_core #(
  parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic signed [tlsm_pkg::DATA_W-1:0] in_elem_value,
  input  logic                              in_load_done,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tlsm_pkg::DATA_W-1:0] out_merged_value,
  output logic                              out_from_second,
  output logic                              out_final_out,
  output logic                              out_overflowed
);
  import tlsm_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic wr_a_en, wr_b_en;
  logic [AW-1:0] waddr_a, waddr_b, raddr_a, raddr_b;
  logic [DATA_W-1:0] rd_a, rd_b;

  tlsm_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem_a (
    .clk     (clk),
    .we      (wr_a_en),
    .waddr   (waddr_a),
    .wdata   (in_elem_value),
    .raddr   (raddr_a),
    .rdata_r (rd_a)
  );

  tlsm_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem_b (
    .clk     (clk),
    .we      (wr_b_en),
    .waddr   (waddr_b),
    .wdata   (in_elem_value),
    .raddr   (raddr_b),
    .rdata_r (rd_b)
  );

  tlsm_merge_seq #(.DEPTH(LIST_DEPTH), .AW(AW), .CW(CW)) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_load_done     (in_load_done),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_merged_value (out_merged_value),
    .out_from_second  (out_from_second),
    .out_final_out    (out_final_out),
    .out_overflowed   (out_overflowed),
    .wr_a_en          (wr_a_en),
    .wr_b_en          (wr_b_en),
    .waddr_a          (waddr_a),
    .waddr_b          (waddr_b),
    .raddr_a          (raddr_a),
    .raddr_b          (raddr_b),
    .rd_a             (rd_a),
    .rd_b             (rd_b)
  );

endmodule

// ===== sv/tlsm_list_mem.sv =====
// Single list storage with one write port and one registered read port.
module tlsm_list_mem #(
  parameter int DEPTH = tlsm_pkg::LIST_DEPTH_DEF,
  parameter int AW = 5
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [tlsm_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [tlsm_pkg::DATA_W-1:0] rdata_r
);
  import tlsm_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== sv/tlsm_merge_seq.sv =====
// Load and merge sequencer with the shared compare unit and result register.
`include "two_list_sorted_merge_core_defines.svh"

module tlsm_merge_seq #(
  parameter int DEPTH = tlsm_pkg::LIST_DEPTH_DEF,
  parameter int AW = 5,
  parameter int CW = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic                              in_load_done,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tlsm_pkg::DATA_W-1:0] out_merged_value,
  output logic                              out_from_second,
  output logic                              out_final_out,
  output logic                              out_overflowed,
  output logic                              wr_a_en,
  output logic                              wr_b_en,
  output logic [AW-1:0]                     waddr_a,
  output logic [AW-1:0]                     waddr_b,
  output logic [AW-1:0]                     raddr_a,
  output logic [AW-1:0]                     raddr_b,
  input  logic [tlsm_pkg::DATA_W-1:0]       rd_a,
  input  logic [tlsm_pkg::DATA_W-1:0]       rd_b
);
  import tlsm_pkg::*;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic drop_r, drop_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic from_second_r, from_second_nxt;
  logic final_r, final_nxt;
  logic ovf_r, ovf_nxt;

  logic accept, load_slot, a_left, b_left, take_first, last_one;
  logic [CW:0] used_sum, total_sum;

  assign in_ready = (state_r == ST_LOAD);
  assign accept = in_valid && in_ready;
  assign load_slot = !out_valid_r || out_ready;
  assign a_left = (ia_r < cnt_a_r);
  assign b_left = (ib_r < cnt_b_r);
  assign take_first = !b_left || (a_left && ($signed(rd_a) <= $signed(rd_b)));
  assign used_sum = {1'b0, ia_r} + {1'b0, ib_r} + (CW+1)'(1);
  assign total_sum = {1'b0, cnt_a_r} + {1'b0, cnt_b_r};
  assign last_one = (used_sum == total_sum);

  assign wr_a_en = accept && !in_mode && (cnt_a_r < DEPTH_C);
  assign wr_b_en = accept && in_mode && (cnt_b_r < DEPTH_C);
  assign waddr_a = cnt_a_r[AW-1:0];
  assign waddr_b = cnt_b_r[AW-1:0];
  assign raddr_a = ia_nxt[AW-1:0];
  assign raddr_b = ib_nxt[AW-1:0];

  assign out_valid = out_valid_r;
  assign out_merged_value = $signed(value_r);
  assign out_from_second = from_second_r;
  assign out_final_out = final_r;
  assign out_overflowed = ovf_r;

  always_comb begin
    state_nxt = state_r;
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ia_nxt = ia_r;
    ib_nxt = ib_r;
    drop_nxt = drop_r;
    out_valid_nxt = out_valid_r;
    value_nxt = value_r;
    from_second_nxt = from_second_r;
    final_nxt = final_r;
    ovf_nxt = ovf_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (!in_mode) begin
            if (cnt_a_r < DEPTH_C) begin
              cnt_a_nxt = cnt_a_r + CW'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end else begin
            if (cnt_b_r < DEPTH_C) begin
              cnt_b_nxt = cnt_b_r + CW'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end
          if (in_load_done) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (load_slot) begin
          out_valid_nxt = 1'b1;
          value_nxt = take_first ? rd_a : rd_b;
          from_second_nxt = !take_first;
          final_nxt = last_one;
          ovf_nxt = drop_r;
          if (take_first) begin
            ia_nxt = ia_r + CW'(1);
          end else begin
            ib_nxt = ib_r + CW'(1);
          end
          if (last_one) begin
            state_nxt = ST_LOAD;
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            ia_nxt = '0;
            ib_nxt = '0;
            drop_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ia_r <= '0;
      ib_r <= '0;
      drop_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      ia_r <= ia_nxt;
      ib_r <= ib_nxt;
      drop_r <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    from_second_r <= from_second_nxt;
    final_r <= final_nxt;
    ovf_r <= ovf_nxt;
  end

  `TLSM_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n,
                      (cnt_a_r <= DEPTH_C) && (cnt_b_r <= DEPTH_C))
  `TLSM_ASSERT_ALWAYS(a_ptr_bound, clk, rst_n, (ia_r <= cnt_a_r) && (ib_r <= cnt_b_r))
  `TLSM_ASSERT_ALWAYS(a_merge_nonempty, clk, rst_n,
                      (state_r != ST_MERGE) || a_left || b_left)
  `TLSM_ASSERT_NEXT(a_done_starts, clk, rst_n, accept && in_load_done, state_r == ST_PREP)
  `TLSM_ASSERT_NEXT(a_last_idle, clk, rst_n,
                    (state_r == ST_MERGE) && load_slot && last_one,
                    (state_r == ST_LOAD) && (cnt_a_r == '0) && (cnt_b_r == '0) && !drop_r)

endmodule
